// ===== rtl/point_transform_2d_top_assert.svh =====
// point_transform_2d_top_assert.svh: assertion macros for the point transform rtl
// needs a clock i_clk and an active-low reset i_rst_n in the including module
`ifndef POINT_TRANSFORM_2D_TOP_ASSERT_SVH
`define POINT_TRANSFORM_2D_TOP_ASSERT_SVH

// condition implies consequence in the same cycle
`define PTR_AST_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// condition implies consequence in the next cycle
`define PTR_AST_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== rtl/ptr_pkg.sv =====
// ptr_pkg: widths, codes, stage payload types and the saturation function
// used by the point transform block; no dependencies
package ptr_pkg;

    // coordinate and fraction widths
    localparam int CW   = 16;
    localparam int FB   = 16;
    localparam int ME   = 8;
    localparam int DW   = CW + 1;
    localparam int TW   = DW + 1;
    localparam int SQW  = 2 * DW;
    localparam int RADW = SQW + 2 * ME;
    localparam int MQW  = RADW / 2;
    localparam int DENW = 2 * MQW - 2 * ME;
    localparam int DOTW = 2 * DW + 1;
    localparam int NUMW = DOTW + FB;
    localparam int UW   = FB + 2;
    localparam int KW   = CW + FB + 1;
    localparam int KHW  = KW - FB + 1;
    localparam int OPW  = (UW > KHW) ? UW : KHW;
    localparam int PW   = DW + OPW;
    localparam int VW   = PW + FB + 1;
    localparam int QW   = VW - FB;
    localparam int SUMW = QW + 1;
    localparam int CNTW = $clog2(NUMW);
    localparam int IDXW = 3;

    // register indexes
    localparam logic [IDXW-1:0] REG_MODE  = 3'd0;
    localparam logic [IDXW-1:0] REG_SRC_X = 3'd1;
    localparam logic [IDXW-1:0] REG_SRC_Y = 3'd2;
    localparam logic [IDXW-1:0] REG_HDL_X = 3'd3;
    localparam logic [IDXW-1:0] REG_HDL_Y = 3'd4;
    localparam logic [IDXW-1:0] REG_CUR_X = 3'd5;
    localparam logic [IDXW-1:0] REG_CUR_Y = 3'd6;

    // operation carried down the pipeline, same codes as the mode register
    typedef enum logic [1:0] {
        OP_PASS  = 2'd0,
        OP_MOVE  = 2'd1,
        OP_ROT   = 2'd2,
        OP_SCALE = 2'd3
    } t_op;

    // coefficient sequencer states
    typedef enum logic [2:0] {
        CS_PROD,
        CS_ROOT_H,
        CS_ROOT_L,
        CS_NORM,
        CS_DIV_C,
        CS_DIV_S,
        CS_DIV_K,
        CS_DONE
    } t_cstate;

    typedef struct packed {
        logic [1:0]             mode;
        logic signed [CW-1:0]   sx;
        logic signed [CW-1:0]   sy;
        logic signed [CW-1:0]   hx;
        logic signed [CW-1:0]   hy;
        logic signed [CW-1:0]   cx;
        logic signed [CW-1:0]   cy;
    } t_cfg;

    typedef struct packed {
        logic                   ready;
        logic signed [UW-1:0]   c;
        logic signed [UW-1:0]   s;
        logic [KW-1:0]          k;
    } t_coef;

    typedef struct packed {
        t_op                    op;
        logic signed [CW-1:0]   x;
        logic signed [CW-1:0]   y;
        logic signed [TW-1:0]   tx;
        logic signed [TW-1:0]   ty;
        logic signed [DW-1:0]   dx;
        logic signed [DW-1:0]   dy;
    } t_s1;

    typedef struct packed {
        t_op                    op;
        logic signed [CW-1:0]   x;
        logic signed [CW-1:0]   y;
        logic signed [TW-1:0]   tx;
        logic signed [TW-1:0]   ty;
        logic signed [PW-1:0]   m1;
        logic signed [PW-1:0]   m2;
        logic signed [PW-1:0]   m3;
        logic signed [PW-1:0]   m4;
    } t_s2;

    typedef struct packed {
        t_op                    op;
        logic signed [CW-1:0]   x;
        logic signed [CW-1:0]   y;
        logic signed [TW-1:0]   tx;
        logic signed [TW-1:0]   ty;
        logic signed [QW-1:0]   qx;
        logic signed [QW-1:0]   qy;
    } t_s3;

    typedef struct packed {
        logic signed [CW-1:0]   out_x;
        logic signed [CW-1:0]   out_y;
        logic                   clip;
    } t_s4;

    typedef struct packed {
        logic signed [CW-1:0]   val;
        logic                   clip;
    } t_sat;

    localparam logic signed [SUMW-1:0] SAT_HI = SUMW'((2 ** (CW - 1)) - 1);
    localparam logic signed [SUMW-1:0] SAT_LO = -SUMW'(2 ** (CW - 1));

    // clamp a wide sum to the coordinate range
    function automatic t_sat sat_coord(input logic signed [SUMW-1:0] v);
        t_sat r;
        if (v > SAT_HI) begin
            r.val  = SAT_HI[CW-1:0];
            r.clip = 1'b1;
        end else if (v < SAT_LO) begin
            r.val  = SAT_LO[CW-1:0];
            r.clip = 1'b1;
        end else begin
            r.val  = v[CW-1:0];
            r.clip = 1'b0;
        end
        return r;
    endfunction

endpackage

// ===== rtl/ptr_cell.sv =====
// ptr_cell: one pipeline cell, a payload register with valid and stall
// depends on nothing; the payload is a flat vector of WIDTH bits
module ptr_cell #(
    parameter int WIDTH = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_stall,
    output logic             o_valid,
    output logic [WIDTH-1:0] o_data,
    input  logic             i_stall
);

    logic             r_valid;
    logic [WIDTH-1:0] r_data;

    // hold only while a request sits here and downstream stalls
    assign o_stall = r_valid & i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!o_stall) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_stall && i_valid) begin
            r_data <= i_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

// ===== rtl/ptr_coef.sv =====
// ptr_coef: configuration registers and the sequencer that derives cos, sin
// and the scale factor with two multipliers, a bit-pair square root and a
// restoring divider; depends on ptr_pkg
module ptr_coef (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [ptr_pkg::IDXW-1:0]     i_cfg_index,
    input  logic [ptr_pkg::CW-1:0]       i_cfg_data,
    output ptr_pkg::t_cfg                o_cfg,
    output ptr_pkg::t_coef               o_coef
);
    import ptr_pkg::*;

    localparam logic [NUMW-1:0] ONE_N  = NUMW'(1) << FB;
    localparam logic [NUMW-1:0] KMAX_N = (NUMW'(1) << KW) - NUMW'(1);

    t_cfg    r_cfg;
    t_cstate r_state, n_state;
    logic [CNTW-1:0] r_cnt, n_cnt;

    logic [SQW-1:0]          r_sqh, r_sql;
    logic signed [DOTW-1:0]  r_dot, r_crs;
    logic [MQW-1:0]          r_hq, r_lq;
    logic [DENW-1:0]         r_den;
    logic signed [UW-1:0]    r_c, r_s;
    logic [KW-1:0]           r_k;
    logic [RADW-1:0]         r_rad;
    logic [MQW-1:0]          r_rem, r_root;
    logic [NUMW-1:0]         r_num, r_quo;
    logic [DENW-1:0]         r_drem;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_MODE:  r_cfg.mode <= i_cfg_data[1:0];
                REG_SRC_X: r_cfg.sx   <= i_cfg_data;
                REG_SRC_Y: r_cfg.sy   <= i_cfg_data;
                REG_HDL_X: r_cfg.hx   <= i_cfg_data;
                REG_HDL_Y: r_cfg.hy   <= i_cfg_data;
                REG_CUR_X: r_cfg.cx   <= i_cfg_data;
                REG_CUR_Y: r_cfg.cy   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // sequencer state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= CS_PROD;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt + CNTW'(1);
        case (r_state)
            CS_PROD: begin
                if (r_cnt == CNTW'(7)) begin
                    n_state = CS_ROOT_H;
                    n_cnt   = '0;
                end
            end
            CS_ROOT_H: begin
                if (r_cnt == CNTW'(MQW - 1)) begin
                    n_state = CS_ROOT_L;
                    n_cnt   = '0;
                end
            end
            CS_ROOT_L: begin
                if (r_cnt == CNTW'(MQW - 1)) begin
                    n_state = CS_NORM;
                    n_cnt   = '0;
                end
            end
            CS_NORM: begin
                n_state = CS_DIV_C;
                n_cnt   = '0;
            end
            CS_DIV_C: begin
                if (r_cnt == CNTW'(NUMW - 1)) begin
                    n_state = CS_DIV_S;
                    n_cnt   = '0;
                end
            end
            CS_DIV_S: begin
                if (r_cnt == CNTW'(NUMW - 1)) begin
                    n_state = CS_DIV_K;
                    n_cnt   = '0;
                end
            end
            CS_DIV_K: begin
                if (r_cnt == CNTW'(NUMW - 1)) begin
                    n_state = CS_DONE;
                    n_cnt   = '0;
                end
            end
            CS_DONE: begin
                n_cnt = '0;
            end
            default: begin
                n_state = CS_PROD;
                n_cnt   = '0;
            end
        endcase
        // any register write starts the derivation over
        if (i_cfg_we) begin
            n_state = CS_PROD;
            n_cnt   = '0;
        end
    end

    // sequencer outputs
    logic first, last_root, last_div, ready;
    always_comb begin
        first     = (r_cnt == '0);
        last_root = (r_cnt == CNTW'(MQW - 1));
        last_div  = (r_cnt == CNTW'(NUMW - 1));
        ready     = (r_state == CS_DONE);
    end

    // offsets from the source
    logic signed [DW-1:0] hdx, hdy, ldx, ldy;
    assign hdx = {r_cfg.hx[CW-1], r_cfg.hx} - {r_cfg.sx[CW-1], r_cfg.sx};
    assign hdy = {r_cfg.hy[CW-1], r_cfg.hy} - {r_cfg.sy[CW-1], r_cfg.sy};
    assign ldx = {r_cfg.cx[CW-1], r_cfg.cx} - {r_cfg.sx[CW-1], r_cfg.sx};
    assign ldy = {r_cfg.cy[CW-1], r_cfg.cy} - {r_cfg.sy[CW-1], r_cfg.sy};

    // shared product unit
    logic signed [DW-1:0]   ma, mb;
    logic signed [2*DW-1:0] prod;
    always_comb begin
        case (r_cnt[2:0])
            3'd0:    begin ma = hdx; mb = hdx; end
            3'd1:    begin ma = hdy; mb = hdy; end
            3'd2:    begin ma = ldx; mb = ldx; end
            3'd3:    begin ma = ldy; mb = ldy; end
            3'd4:    begin ma = hdx; mb = ldx; end
            3'd5:    begin ma = hdy; mb = ldy; end
            3'd6:    begin ma = hdx; mb = ldy; end
            default: begin ma = hdy; mb = ldx; end
        endcase
        prod = ma * mb;
    end

    logic signed [DOTW-1:0] prod_x;
    assign prod_x = DOTW'(prod);

    // square root step, two radicand bits per cycle
    logic [RADW-1:0] rad_i, rad_n;
    logic [MQW-1:0]  rem_i, root_i, root_n;
    logic [MQW+1:0]  rem_s, trial, rem_n;
    logic            sq_ge;
    always_comb begin
        if (first) begin
            rad_i  = (r_state == CS_ROOT_H) ? {r_sqh, {(2*ME){1'b0}}}
                                            : {r_sql, {(2*ME){1'b0}}};
            rem_i  = '0;
            root_i = '0;
        end else begin
            rad_i  = r_rad;
            rem_i  = r_rem;
            root_i = r_root;
        end
        rem_s  = {rem_i, rad_i[RADW-1:RADW-2]};
        trial  = {root_i, 2'b01};
        sq_ge  = (rem_s >= trial);
        rem_n  = sq_ge ? (rem_s - trial) : rem_s;
        root_n = {root_i[MQW-2:0], sq_ge};
        rad_n  = rad_i << 2;
    end

    // divider operands
    logic              neg;
    logic [DOTW-1:0]   mag;
    logic [NUMW-1:0]   num_init;
    logic [DENW-1:0]   dvs;
    always_comb begin
        neg = 1'b0;
        mag = '0;
        dvs = r_den;
        case (r_state)
            CS_DIV_C: begin
                neg = r_dot[DOTW-1];
                mag = neg ? DOTW'(-r_dot) : DOTW'(r_dot);
            end
            CS_DIV_S: begin
                neg = r_crs[DOTW-1];
                mag = neg ? DOTW'(-r_crs) : DOTW'(r_crs);
            end
            CS_DIV_K: begin
                dvs = (r_hq == '0) ? DENW'(1) : DENW'(r_hq);
            end
            default: ;
        endcase
        if (r_state == CS_DIV_K) begin
            num_init = NUMW'(r_lq) << FB;
        end else begin
            num_init = NUMW'(mag) << FB;
        end
    end

    // restoring divide step, one quotient bit per cycle
    logic [NUMW-1:0] num_i, num_n, quo_i, quo_n;
    logic [DENW-1:0] drem_i;
    logic [DENW:0]   drs, drem_n;
    logic            d_ge;
    always_comb begin
        num_i  = first ? num_init : r_num;
        drem_i = first ? '0 : r_drem;
        quo_i  = first ? '0 : r_quo;
        drs    = {drem_i, num_i[NUMW-1]};
        d_ge   = (drs >= {1'b0, dvs});
        drem_n = d_ge ? (drs - {1'b0, dvs}) : drs;
        quo_n  = {quo_i[NUMW-2:0], d_ge};
        num_n  = num_i << 1;
    end

    // clamped results
    logic [FB:0]          unit_mag;
    logic signed [UW-1:0] unit_val;
    logic [KW-1:0]        k_val;
    logic [2*MQW-1:0]     norm_prod;
    logic [DENW-1:0]      den_n;
    always_comb begin
        unit_mag  = (quo_n > ONE_N) ? ONE_N[FB:0] : quo_n[FB:0];
        unit_val  = neg ? -UW'(unit_mag) : UW'(unit_mag);
        k_val     = (quo_n > KMAX_N) ? KMAX_N[KW-1:0] : quo_n[KW-1:0];
        norm_prod = r_hq * r_lq;
        den_n     = norm_prod[2*MQW-1:2*ME];
        if (den_n == '0) begin
            den_n = DENW'(1);
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            CS_PROD: begin
                case (r_cnt[2:0])
                    3'd0:    r_sqh <= SQW'(prod);
                    3'd1:    r_sqh <= r_sqh + SQW'(prod);
                    3'd2:    r_sql <= SQW'(prod);
                    3'd3:    r_sql <= r_sql + SQW'(prod);
                    3'd4:    r_dot <= prod_x;
                    3'd5:    r_dot <= r_dot + prod_x;
                    3'd6:    r_crs <= prod_x;
                    default: r_crs <= r_crs - prod_x;
                endcase
            end
            CS_ROOT_H, CS_ROOT_L: begin
                r_rad  <= rad_n;
                r_rem  <= rem_n[MQW-1:0];
                r_root <= root_n;
                if (last_root && r_state == CS_ROOT_H) begin
                    r_hq <= root_n;
                end
                if (last_root && r_state == CS_ROOT_L) begin
                    r_lq <= root_n;
                end
            end
            CS_NORM: begin
                r_den <= den_n;
            end
            CS_DIV_C, CS_DIV_S, CS_DIV_K: begin
                r_num  <= num_n;
                r_drem <= drem_n[DENW-1:0];
                r_quo  <= quo_n;
                if (last_div) begin
                    case (r_state)
                        CS_DIV_C: r_c <= unit_val;
                        CS_DIV_S: r_s <= unit_val;
                        default:  r_k <= k_val;
                    endcase
                end
            end
            default: ;
        endcase
    end

    assign o_cfg        = r_cfg;
    assign o_coef.ready = ready;
    assign o_coef.c     = r_c;
    assign o_coef.s     = r_s;
    assign o_coef.k     = r_k;

endmodule

// ===== rtl/point_transform_2d_top.sv =====
// point_transform_2d_top: an accepted request is registered in u_cell1 to u_cell4
// on its way to its result; throughput one point per cycle under fixed configuration
// while the output does not stall. after reset and after every register write the
// coefficient sequencer runs 8 products, two 25-step roots, 1 norm and three
// 51-step divides, and the input stalls until it is done. reset is synchronous,
// active low, and clears the configuration registers and the pipeline valid bits.
module point_transform_2d_top (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic signed [ptr_pkg::CW-1:0] i_in_x,
    input  logic signed [ptr_pkg::CW-1:0] i_in_y,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic signed [ptr_pkg::CW-1:0] o_out_x,
    output logic signed [ptr_pkg::CW-1:0] o_out_y,
    output logic                          o_clipped,
    input  logic                          i_cfg_we,
    input  logic [ptr_pkg::IDXW-1:0]      i_cfg_index,
    input  logic [ptr_pkg::CW-1:0]        i_cfg_data
);
    import ptr_pkg::*;
    `include "point_transform_2d_top_assert.svh"

    localparam logic [VW-1:0] FRAC_MASK = (VW'(1) << FB) - VW'(1);

    t_cfg  cfg;
    t_coef coef;

    ptr_coef u_coef (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg),
        .o_coef      (coef)
    );

    t_s1 s1_n, s1;
    t_s2 s2_n, s2;
    t_s3 s3_n, s3;
    t_s4 s4_n, s4;
    logic c1_valid, c2_valid, c3_valid, c4_valid;
    logic c1_up, c2_up, c3_up, c4_up;
    logic [$bits(t_s1)-1:0] c1_q;
    logic [$bits(t_s2)-1:0] c2_q;
    logic [$bits(t_s3)-1:0] c3_q;
    logic [$bits(t_s4)-1:0] c4_q;

    // stage a: offsets, translate sums, operation select
    logic signed [DW-1:0] lx, ly;
    logic                 pass;
    always_comb begin
        lx   = {cfg.cx[CW-1], cfg.cx} - {cfg.sx[CW-1], cfg.sx};
        ly   = {cfg.cy[CW-1], cfg.cy} - {cfg.sy[CW-1], cfg.sy};
        pass = (cfg.mode == OP_PASS) || (cfg.cx == cfg.sx && cfg.cy == cfg.sy)
            || ((cfg.mode == OP_ROT || cfg.mode == OP_SCALE)
                && cfg.hx == cfg.sx && cfg.hy == cfg.sy);
        case (cfg.mode)
            OP_MOVE:  s1_n.op = OP_MOVE;
            OP_ROT:   s1_n.op = OP_ROT;
            OP_SCALE: s1_n.op = OP_SCALE;
            default:  s1_n.op = OP_PASS;
        endcase
        if (pass) begin
            s1_n.op = OP_PASS;
        end
        s1_n.x  = i_in_x;
        s1_n.y  = i_in_y;
        s1_n.dx = {i_in_x[CW-1], i_in_x} - {cfg.sx[CW-1], cfg.sx};
        s1_n.dy = {i_in_y[CW-1], i_in_y} - {cfg.sy[CW-1], cfg.sy};
        s1_n.tx = TW'($signed(i_in_x)) + TW'(lx);
        s1_n.ty = TW'($signed(i_in_y)) + TW'(ly);
    end

    ptr_cell #(.WIDTH($bits(t_s1))) u_cell1 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid & coef.ready),
        .i_data  (s1_n),
        .o_stall (c1_up),
        .o_valid (c1_valid),
        .o_data  (c1_q),
        .i_stall (c2_up)
    );
    assign s1 = t_s1'(c1_q);
    assign o_in_stall = !coef.ready | c1_up;

    // stage b: four shared multipliers, rotate or split scale factor
    logic signed [OPW-1:0] op_c, op_s, op_kh, op_kl;
    always_comb begin
        op_c  = OPW'(coef.c);
        op_s  = OPW'(coef.s);
        op_kh = OPW'({1'b0, coef.k[KW-1:FB]});
        op_kl = OPW'({1'b0, coef.k[FB-1:0]});
        s2_n.op = s1.op;
        s2_n.x  = s1.x;
        s2_n.y  = s1.y;
        s2_n.tx = s1.tx;
        s2_n.ty = s1.ty;
        if (s1.op == OP_ROT) begin
            s2_n.m1 = s1.dx * op_c;
            s2_n.m2 = s1.dy * op_s;
            s2_n.m3 = s1.dx * op_s;
            s2_n.m4 = s1.dy * op_c;
        end else begin
            s2_n.m1 = s1.dx * op_kh;
            s2_n.m2 = s1.dy * op_kh;
            s2_n.m3 = s1.dx * op_kl;
            s2_n.m4 = s1.dy * op_kl;
        end
    end

    ptr_cell #(.WIDTH($bits(t_s2))) u_cell2 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (c1_valid),
        .i_data  (s2_n),
        .o_stall (c2_up),
        .o_valid (c2_valid),
        .o_data  (c2_q),
        .i_stall (c3_up)
    );
    assign s2 = t_s2'(c2_q);

    // stage c: combine products, drop fraction toward zero
    logic signed [VW-1:0] e1, e2, e3, e4, vx, vy, ax, ay;
    always_comb begin
        e1 = VW'($signed(s2.m1));
        e2 = VW'($signed(s2.m2));
        e3 = VW'($signed(s2.m3));
        e4 = VW'($signed(s2.m4));
        if (s2.op == OP_ROT) begin
            vx = e1 - e2;
            vy = e3 + e4;
        end else begin
            vx = (e1 <<< FB) + e3;
            vy = (e2 <<< FB) + e4;
        end
        ax = vx + (vx[VW-1] ? FRAC_MASK : '0);
        ay = vy + (vy[VW-1] ? FRAC_MASK : '0);
        s3_n.op = s2.op;
        s3_n.x  = s2.x;
        s3_n.y  = s2.y;
        s3_n.tx = s2.tx;
        s3_n.ty = s2.ty;
        s3_n.qx = ax[VW-1:FB];
        s3_n.qy = ay[VW-1:FB];
    end

    ptr_cell #(.WIDTH($bits(t_s3))) u_cell3 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (c2_valid),
        .i_data  (s3_n),
        .o_stall (c3_up),
        .o_valid (c3_valid),
        .o_data  (c3_q),
        .i_stall (c4_up)
    );
    assign s3 = t_s3'(c3_q);

    // stage d: add the source back, pick the result, saturate
    logic signed [SUMW-1:0] wx, wy;
    t_sat                   sat_x, sat_y;
    always_comb begin
        case (s3.op)
            OP_MOVE: begin
                wx = SUMW'($signed(s3.tx));
                wy = SUMW'($signed(s3.ty));
            end
            OP_ROT, OP_SCALE: begin
                wx = SUMW'($signed(cfg.sx)) + SUMW'($signed(s3.qx));
                wy = SUMW'($signed(cfg.sy)) + SUMW'($signed(s3.qy));
            end
            default: begin
                wx = SUMW'($signed(s3.x));
                wy = SUMW'($signed(s3.y));
            end
        endcase
        sat_x      = sat_coord(wx);
        sat_y      = sat_coord(wy);
        s4_n.out_x = sat_x.val;
        s4_n.out_y = sat_y.val;
        s4_n.clip  = sat_x.clip | sat_y.clip;
    end

    // output register
    ptr_cell #(.WIDTH($bits(t_s4))) u_cell4 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (c3_valid),
        .i_data  (s4_n),
        .o_stall (c4_up),
        .o_valid (c4_valid),
        .o_data  (c4_q),
        .i_stall (i_out_stall)
    );
    assign s4          = t_s4'(c4_q);
    assign o_out_valid = c4_valid;
    assign o_out_x     = s4.out_x;
    assign o_out_y     = s4.out_y;
    assign o_clipped   = s4.clip;

    // checks
    `PTR_AST_IMP(a_stall_while_deriving, !coef.ready, o_in_stall)
    `PTR_AST_NXT(a_write_restarts, i_cfg_we, !coef.ready)
    `PTR_AST_IMP(a_pass_never_clips, c3_valid && s3.op == OP_PASS, !s4_n.clip)

endmodule
